/* hdl/hnk_pkg.sv */
// Package for the HDLC NRZI receiver with KISS framing.
// Holds the framing constants, the queue entry type and the KISS escape function.
// No dependencies; every other file in hdl imports it.
package hnk_pkg;

    // Trailing FCS bytes that are held back and never sent.
    localparam int FCS_BYTES   = 2;
    localparam int HELD_DEPTH  = FCS_BYTES + 1;
    localparam int HELD_CNT_W  = $clog2(HELD_DEPTH + 1);

    // Depth of the queue between the framer and the output serializer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDLC_FLAG      = 8'h7E;
    localparam logic [7:0] KISS_FEND      = 8'hC0;
    localparam logic [7:0] KISS_FESC      = 8'hDB;
    localparam logic [7:0] KISS_TFEND     = 8'hDC;
    localparam logic [7:0] KISS_TFESC     = 8'hDD;
    localparam logic [3:0] KISS_DATA_TYPE = 4'h0;

    // The one or two output bytes produced by a single bit tick.
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } hnk_bundle_t;

    function automatic hnk_bundle_t kiss_escape(input logic [7:0] b);
        hnk_bundle_t r;
        r.two = 1'b0;
        r.b0  = b;
        r.b1  = 8'h00;
        if (b == KISS_FEND)
        begin
            r.two = 1'b1;
            r.b0  = KISS_FESC;
            r.b1  = KISS_TFEND;
        end
        else if (b == KISS_FESC)
        begin
            r.two = 1'b1;
            r.b0  = KISS_FESC;
            r.b1  = KISS_TFESC;
        end
        return r;
    endfunction

endpackage

/* hdl/hnk_front.sv */
// Front end: NRZI decode, bit destuffing, flag hunt, byte framing and FCS delay line.
// Produces one bundle of output bytes per bit tick that has any.
// Depends on hnk_pkg.
module hnk_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                carrier_present,
    input  logic                line_level,
    input  logic                cfg_valid,
    input  logic [3:0]          cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output hnk_pkg::hnk_bundle_t q_din
);
    import hnk_pkg::*;

    logic                  prev_reg, prev_next;
    logic [2:0]            ones_reg, ones_next;
    logic [7:0]            shift_reg, shift_next;
    logic [3:0]            bitcnt_reg, bitcnt_next;
    logic                  flag_seen_reg, flag_seen_next;
    logic                  in_frame_reg, in_frame_next;
    logic [7:0]            held_reg [HELD_DEPTH];
    logic [7:0]            held_next [HELD_DEPTH];
    logic [HELD_CNT_W-1:0] held_cnt_reg, held_cnt_next;
    logic [3:0]            port_reg;
    logic                  accept;
    logic [1:0]            n_out;
    logic [7:0]            o0, o1;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hnk_bundle_t esc;
        logic        bit_val;
        logic        keep;

        esc            = '0;
        bit_val        = 1'b0;
        keep           = 1'b0;
        prev_next      = prev_reg;
        ones_next      = ones_reg;
        shift_next     = shift_reg;
        bitcnt_next    = bitcnt_reg;
        flag_seen_next = flag_seen_reg;
        in_frame_next  = in_frame_reg;
        held_next      = held_reg;
        held_cnt_next  = held_cnt_reg;
        n_out          = 2'd0;
        o0             = 8'h00;
        o1             = 8'h00;

        if (accept && carrier_present)
        begin
            // A release deferred from the previous tick goes out first.
            if (held_cnt_next > HELD_CNT_W'(FCS_BYTES))
            begin
                esc = kiss_escape(held_next[0]);
                for (int i = 0; i < HELD_DEPTH - 1; i++)
                begin
                    held_next[i] = held_next[i + 1];
                end
                held_cnt_next = held_cnt_next - 1'b1;
                o0    = esc.b0;
                o1    = esc.b1;
                n_out = esc.two ? 2'd2 : 2'd1;
            end

            if (line_level != prev_reg)
            begin
                bit_val   = 1'b0;
                keep      = (ones_reg != 3'd5);
                ones_next = 3'd0;
            end
            else
            begin
                bit_val = 1'b1;
                keep    = 1'b1;
                if (ones_reg != 3'd7)
                begin
                    ones_next = ones_reg + 1'b1;
                end
            end
            prev_next = line_level;

            if (keep)
            begin
                shift_next  = {bit_val, shift_reg[7:1]};
                bitcnt_next = bitcnt_reg + 1'b1;
            end

            if (!flag_seen_reg)
            begin
                if (shift_next == HDLC_FLAG)
                begin
                    flag_seen_next = 1'b1;
                    bitcnt_next    = 4'd8;
                end
                else
                begin
                    bitcnt_next = 4'd0;
                end
            end

            // A whole byte aligned to the flag. Nothing is pending here, since a
            // deferred release can only sit on a tick that cannot complete a byte.
            if (flag_seen_next && bitcnt_next[3])
            begin
                if (shift_next == HDLC_FLAG)
                begin
                    ones_next = 3'd0;
                    if (in_frame_reg)
                    begin
                        in_frame_next  = 1'b0;
                        flag_seen_next = 1'b0;
                        held_cnt_next  = '0;
                        o0    = KISS_FEND;
                        n_out = 2'd1;
                    end
                end
                else
                begin
                    if (!in_frame_reg)
                    begin
                        in_frame_next = 1'b1;
                        o0    = KISS_FEND;
                        o1    = {port_reg, KISS_DATA_TYPE};
                        n_out = 2'd2;
                    end
                    if (held_cnt_next <= HELD_CNT_W'(FCS_BYTES))
                    begin
                        for (int i = 0; i < HELD_DEPTH; i++)
                        begin
                            if (HELD_CNT_W'(i) == held_cnt_next)
                            begin
                                held_next[i] = shift_next;
                            end
                        end
                        held_cnt_next = held_cnt_next + 1'b1;
                    end
                    if (held_cnt_next > HELD_CNT_W'(FCS_BYTES) && n_out == 2'd0)
                    begin
                        esc = kiss_escape(held_next[0]);
                        for (int i = 0; i < HELD_DEPTH - 1; i++)
                        begin
                            held_next[i] = held_next[i + 1];
                        end
                        held_cnt_next = held_cnt_next - 1'b1;
                        o0    = esc.b0;
                        o1    = esc.b1;
                        n_out = esc.two ? 2'd2 : 2'd1;
                    end
                end
                shift_next  = 8'h00;
                bitcnt_next = 4'd0;
            end
        end
    end

    assign q_push = accept && (n_out != 2'd0);
    assign q_din  = {(n_out == 2'd2), o0, o1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 1'b0;
            ones_reg      <= 3'd0;
            shift_reg     <= 8'h00;
            bitcnt_reg    <= 4'd0;
            flag_seen_reg <= 1'b0;
            in_frame_reg  <= 1'b0;
            held_cnt_reg  <= '0;
            port_reg      <= 4'd0;
        end
        else
        begin
            prev_reg      <= prev_next;
            ones_reg      <= ones_next;
            shift_reg     <= shift_next;
            bitcnt_reg    <= bitcnt_next;
            flag_seen_reg <= flag_seen_next;
            in_frame_reg  <= in_frame_next;
            held_cnt_reg  <= held_cnt_next;
            if (cfg_valid)
            begin
                port_reg <= cfg_data;
            end
        end
    end

    // Delay line contents are only read below the fill count.
    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

/* hdl/hnk_queue.sv */
// Small queue of output bundles between the framer and the serializer.
// Depends on hnk_pkg.
module hnk_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hnk_pkg::hnk_bundle_t din,
    output logic                 full,
    input  logic                 pop,
    output hnk_pkg::hnk_bundle_t dout,
    output logic                 empty
);
    import hnk_pkg::*;

    hnk_bundle_t            mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push, do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/hnk_back.sv */
// Back end: splits each queued bundle into single bytes on the output stream.
// Holds the output register; depends on hnk_pkg.
module hnk_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hnk_pkg::hnk_bundle_t q_dout,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_data,
    output logic                 out_last
);
    import hnk_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       phase_reg, phase_next;
    logic       load;
    logic [7:0] data_next;
    logic       last_next;

    assign load = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        q_pop      = 1'b0;
        data_next  = q_dout.b0;
        last_next  = !q_dout.two;
        if (phase_reg)
        begin
            data_next = q_dout.b1;
            last_next = 1'b1;
        end
        if (load)
        begin
            if (!phase_reg && q_dout.two)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                q_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

/* hdl/hdlc_nrzi_receiver_kiss_framer_top.sv */
// Channel  | Handshake                     | Payload
// s_axis   | s_axis_tvalid / s_axis_tready | tdata[0] line_level, tuser carrier_present
// m_axis   | m_axis_tvalid / m_axis_tready | tdata kiss_byte, tlast last_of_run
// cfg      | cfg_valid / cfg_ready         | cfg_data kiss_port
//
// One bit tick is taken every clock while the four-entry bundle queue has room.
// Each result byte leaves one per clock while m_axis_tready is high; with the queue
// empty, the first byte of a tick passes through its queue entry and then the output
// register. A tick that yields two bytes holds its queue entry for two output
// transfers. Reset (rst_n low, asynchronous) clears the decoder, framer, queue and
// output register. The configuration port is always ready.
module hdlc_nrzi_receiver_kiss_framer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] line_level, [7:1] zero
    input  logic       s_axis_tuser,   // [0] carrier_present
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] kiss_byte
    output logic       m_axis_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);
    import hnk_pkg::*;

    hnk_bundle_t q_din, q_dout;
    logic        q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    hnk_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .carrier_present (s_axis_tuser),
        .line_level      (s_axis_tdata[0]),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_din           (q_din)
    );

    hnk_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    hnk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_dout    (q_dout),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
